// ===== rtl/vcbm_pkg.sv =====
// Shared types, constants and helper functions of the voxel column bit mask.
`default_nettype none
package vcbm_pkg;

    localparam int MAX_LEVELS_DEF  = 512;
    localparam int SLICE_BITS      = 8;
    localparam int WORDS_PER_LEVEL = 1 << (SLICE_BITS - 6);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LEVEL  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_COUNT = 1'd1;

    localparam logic signed [15:0] BASE_LEVEL_RST  = -16'sd64;
    localparam logic [9:0]         LEVEL_COUNT_RST = 10'd384;

    typedef enum logic [2:0] {
        REQ_TEST  = 3'd0,
        REQ_SET   = 3'd1,
        REQ_CLEAR = 3'd2,
        REQ_COUNT = 3'd3,
        REQ_READ  = 3'd4,
        REQ_LOAD  = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR,
        ST_COUNT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic access_write;
        logic wipe;
        logic walk_read;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic walk_last;
        logic walk_busy;
        logic out_free;
    } status_t;

    function automatic logic [6:0] popcount64(input logic [63:0] w);
        logic [63:0] s;
        s = (w & 64'h5555_5555_5555_5555) + ((w >> 1) & 64'h5555_5555_5555_5555);
        s = (s & 64'h3333_3333_3333_3333) + ((s >> 2) & 64'h3333_3333_3333_3333);
        s = (s & 64'h0F0F_0F0F_0F0F_0F0F) + ((s >> 4) & 64'h0F0F_0F0F_0F0F_0F0F);
        s = (s & 64'h00FF_00FF_00FF_00FF) + ((s >> 8) & 64'h00FF_00FF_00FF_00FF);
        s = (s & 64'h0000_FFFF_0000_FFFF) + ((s >> 16) & 64'h0000_FFFF_0000_FFFF);
        s = (s & 64'h0000_0000_FFFF_FFFF) + ((s >> 32) & 64'h0000_0000_FFFF_FFFF);
        return s[6:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/voxel_column_bit_mask.sv =====
// Top level of the voxel column bit mask: sequencer plus datapath.
//
// Requests arrive on the in_valid/in_ready channel, one beat per request, and
// each gives exactly one result beat on out_valid/out_ready. Configuration is
// written through cfg_write_en/cfg_index/cfg_data; the user is to write it
// only while the block is idle, which the block itself does not enforce.
// Test, set, read word and load word are accepted with a mask memory read in
// ST_IDLE, then write back in ST_ACCESS and post the result there, or in
// ST_FINISH while the previous result is still held. Count walks the words
// in use through the single memory read port and a popcount stage. Clear
// writes zero to every word through the write port. After reset the same
// clearing pass runs with in_ready low; configuration writes are taken
// meanwhile. The result sits in an output register; a request is accepted
// while the previous result still waits, and a stalled receiver holds the
// block only when the next result is ready to be posted.
`default_nettype none
module voxel_column_bit_mask #(
    parameter int MAX_LEVELS = vcbm_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [vcbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [vcbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [2:0]                        req_type,
    input  wire logic [3:0]                        cell_x,
    input  wire logic signed [15:0]                cell_y,
    input  wire logic [3:0]                        cell_z,
    input  wire logic [10:0]                       word_index,
    input  wire logic [63:0]                       word_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   cell_bit,
    output logic [17:0]                            set_count,
    output logic [11:0]                            used_words,
    output logic [63:0]                            word_value
);

    vcbm_pkg::cmd_t    cmd;
    vcbm_pkg::status_t status;

    vcbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    vcbm_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .word_index   (word_index),
        .word_data    (word_data),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .cell_bit     (cell_bit),
        .set_count    (set_count),
        .used_words   (used_words),
        .word_value   (word_value)
    );

endmodule
`default_nettype wire

// ===== rtl/vcbm_ctrl.sv =====
// Request sequencer of the voxel column bit mask.
`default_nettype none
module vcbm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        req_type,
    input  wire vcbm_pkg::status_t status,
    output vcbm_pkg::cmd_t         cmd
);

    vcbm_pkg::state_t state_reg;
    vcbm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vcbm_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            vcbm_pkg::ST_INIT:
            begin
                cmd.wipe = 1'b1;
                if (status.walk_last)
                begin
                    state_next = vcbm_pkg::ST_IDLE;
                end
            end
            vcbm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (req_type)
                        vcbm_pkg::REQ_CLEAR: state_next = vcbm_pkg::ST_CLEAR;
                        vcbm_pkg::REQ_COUNT: state_next = vcbm_pkg::ST_COUNT;
                        default:             state_next = vcbm_pkg::ST_ACCESS;
                    endcase
                end
            end
            vcbm_pkg::ST_ACCESS:
            begin
                cmd.access_write = 1'b1;
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = vcbm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = vcbm_pkg::ST_FINISH;
                end
            end
            vcbm_pkg::ST_CLEAR:
            begin
                cmd.wipe = 1'b1;
                if (status.walk_last)
                begin
                    state_next = vcbm_pkg::ST_FINISH;
                end
            end
            vcbm_pkg::ST_COUNT:
            begin
                if (!status.walk_done)
                begin
                    cmd.walk_read = 1'b1;
                end
                else if (!status.walk_busy)
                begin
                    state_next = vcbm_pkg::ST_FINISH;
                end
            end
            vcbm_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = vcbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vcbm_pkg::ST_INIT;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/vcbm_dp.sv =====
// Datapath of the voxel column bit mask: config, mask memory, count pipeline, result.
`default_nettype none
module vcbm_dp #(
    parameter int MAX_LEVELS = vcbm_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [vcbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [vcbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [2:0]                        req_type,
    input  wire logic [3:0]                        cell_x,
    input  wire logic signed [15:0]                cell_y,
    input  wire logic [3:0]                        cell_z,
    input  wire logic [10:0]                       word_index,
    input  wire logic [63:0]                       word_data,
    input  wire vcbm_pkg::cmd_t                    cmd,
    output vcbm_pkg::status_t                      status,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic                                   cell_bit,
    output logic [17:0]                            set_count,
    output logic [11:0]                            used_words,
    output logic [63:0]                            word_value
);

    localparam int STORE_WORDS = MAX_LEVELS * vcbm_pkg::WORDS_PER_LEVEL;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [ADDR_W:0] WALK_LAST = (ADDR_W + 1)'(STORE_WORDS - 1);

    logic signed [15:0] base_level_reg;
    logic [9:0]         level_count_reg;

    logic [63:0] mem [STORE_WORDS];

    logic [2:0]        req_type_reg;
    logic              acc_ok_reg;
    logic [ADDR_W-1:0] acc_addr_reg;
    logic [5:0]        bit_idx_reg;
    logic [63:0]       word_data_reg;

    logic [ADDR_W:0]   walk_addr_reg;
    logic [63:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic              pop_valid_reg;
    logic [6:0]        pop_reg;
    logic              pop_nz_reg;
    logic [ADDR_W-1:0] pop_idx_reg;
    logic [17:0]       cnt_reg;
    logic [11:0]       used_reg;

    logic              out_valid_reg;
    logic              cell_bit_reg;
    logic [17:0]       set_count_reg;
    logic [11:0]       used_words_reg;
    logic [63:0]       word_value_reg;

    logic [15:0]        height;
    logic [15:0]        live_words;
    logic signed [16:0] rel;
    logic               cell_ok;
    logic [15:0]        cell_word;
    logic               word_ok;
    logic               is_cell;
    logic               sel_ok;
    logic [ADDR_W-1:0]  sel_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [63:0]        wr_data;
    logic [15:0]        used_sum;

    logic               res_bit;
    logic [17:0]        res_count;
    logic [11:0]        res_used;
    logic [63:0]        res_value;

    assign height = (16'(level_count_reg) > 16'(MAX_LEVELS)) ? 16'(MAX_LEVELS)
                                                            : 16'(level_count_reg);
    assign live_words = 16'(height * 16'(vcbm_pkg::WORDS_PER_LEVEL));

    assign rel       = {cell_y[15], cell_y} - {base_level_reg[15], base_level_reg};
    assign cell_ok   = !rel[16] && (rel[15:0] < height);
    assign cell_word = {rel[13:0], cell_z[3:2]};
    assign word_ok   = 16'(word_index) < live_words;

    assign is_cell  = (req_type == vcbm_pkg::REQ_TEST) || (req_type == vcbm_pkg::REQ_SET);
    assign sel_ok   = is_cell ? cell_ok : word_ok;
    assign sel_addr = is_cell ? cell_word[ADDR_W-1:0] : ADDR_W'(word_index);

    assign rd_en   = cmd.accept || cmd.walk_read;
    assign rd_addr = cmd.walk_read ? walk_addr_reg[ADDR_W-1:0] : sel_addr;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = acc_addr_reg;
        wr_data = word_data_reg;
        if (cmd.wipe)
        begin
            wr_en   = 1'b1;
            wr_addr = walk_addr_reg[ADDR_W-1:0];
            wr_data = '0;
        end
        else if (cmd.access_write && acc_ok_reg)
        begin
            if (req_type_reg == vcbm_pkg::REQ_SET)
            begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg | (64'd1 << bit_idx_reg);
            end
            else if (req_type_reg == vcbm_pkg::REQ_LOAD)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_level_reg  <= vcbm_pkg::BASE_LEVEL_RST;
            level_count_reg <= vcbm_pkg::LEVEL_COUNT_RST;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == vcbm_pkg::CFG_BASE_LEVEL)
            begin
                base_level_reg <= $signed(cfg_data);
            end
            else if (cfg_index == vcbm_pkg::CFG_LEVEL_COUNT)
            begin
                level_count_reg <= cfg_data[9:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg  <= req_type;
            acc_ok_reg    <= sel_ok;
            acc_addr_reg  <= sel_addr;
            bit_idx_reg   <= {cell_z[1:0], cell_x};
            word_data_reg <= word_data;
        end
        rd_idx_reg  <= walk_addr_reg[ADDR_W-1:0];
        pop_reg     <= vcbm_pkg::popcount64(rd_data_reg);
        pop_nz_reg  <= |rd_data_reg;
        pop_idx_reg <= rd_idx_reg;
    end

    assign used_sum = 16'(pop_idx_reg) + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            pop_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            used_reg      <= '0;
        end
        else
        begin
            rd_valid_reg  <= cmd.walk_read;
            pop_valid_reg <= rd_valid_reg;
            if (cmd.accept)
            begin
                walk_addr_reg <= '0;
            end
            else if (cmd.wipe || cmd.walk_read)
            begin
                walk_addr_reg <= walk_addr_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                cnt_reg  <= '0;
                used_reg <= '0;
            end
            else if (pop_valid_reg)
            begin
                cnt_reg <= cnt_reg + 18'(pop_reg);
                if (pop_nz_reg)
                begin
                    used_reg <= used_sum[11:0];
                end
            end
        end
    end

    always_comb
    begin
        res_bit   = 1'b0;
        res_count = '0;
        res_used  = '0;
        res_value = '0;
        case (req_type_reg)
            vcbm_pkg::REQ_TEST:  res_bit   = acc_ok_reg && rd_data_reg[bit_idx_reg];
            vcbm_pkg::REQ_SET:   res_bit   = acc_ok_reg;
            vcbm_pkg::REQ_COUNT:
            begin
                res_count = cnt_reg;
                res_used  = used_reg;
            end
            vcbm_pkg::REQ_READ:  res_value = acc_ok_reg ? rd_data_reg : '0;
            vcbm_pkg::REQ_LOAD:  res_value = acc_ok_reg ? word_data_reg : '0;
            default:             res_bit   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            cell_bit_reg   <= res_bit;
            set_count_reg  <= res_count;
            used_words_reg <= res_used;
            word_value_reg <= res_value;
        end
    end

    assign status.walk_done = 16'(walk_addr_reg) >= live_words;
    assign status.walk_last = walk_addr_reg == WALK_LAST;
    assign status.walk_busy = rd_valid_reg || pop_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign cell_bit   = cell_bit_reg;
    assign set_count  = set_count_reg;
    assign used_words = used_words_reg;
    assign word_value = word_value_reg;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for voxel_column_bit_mask: directed and random requests checked against a behavioral mask.
module tb;
    import vcbm_pkg::*;

    localparam int MAX_LEVELS  = MAX_LEVELS_DEF;
    localparam int STORE_WORDS = MAX_LEVELS * WORDS_PER_LEVEL;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 104;
    localparam int REPLY_DEPTH = 16;

    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

    typedef struct packed {
        logic        cell_bit;
        logic [17:0] set_count;
        logic [11:0] used_words;
        logic [63:0] word_value;
    } mask_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [2:0]             req_type;
    logic [3:0]             cell_x;
    logic signed [15:0]     cell_y;
    logic [3:0]             cell_z;
    logic [10:0]            word_index;
    logic [63:0]            word_data;
    logic                   out_valid;
    logic                   out_ready;
    logic                   cell_bit;
    logic [17:0]            set_count;
    logic [11:0]            used_words;
    logic [63:0]            word_value;

    logic [63:0]        column_words [STORE_WORDS];
    logic signed [15:0] base_level_now;
    logic [9:0]         level_count_now;
    mask_result_t       reply_fifo [REPLY_DEPTH];
    int                 reply_wr_count;
    int                 reply_rd_count;
    mask_result_t       reply_front;
    int                 err_count;
    bit                 tx_idle_en;
    bit                 rx_idle_en;
    bit                 long_hold_req;
    logic [3:0]         last_x;
    logic [3:0]         last_z;
    logic signed [15:0] last_y;

    voxel_column_bit_mask #(.MAX_LEVELS(MAX_LEVELS)) uut (.*);

    function automatic int live_height();
        return (int'(level_count_now) > MAX_LEVELS) ? MAX_LEVELS : int'(level_count_now);
    endfunction

    function automatic mask_result_t mask_reply_for(input logic [2:0] req,
            input logic [3:0] x, input logic signed [15:0] y, input logic [3:0] z,
            input logic [10:0] widx, input logic [63:0] wdata);
        mask_result_t r;
        int           rel;
        int           nwords;
        int           cidx;
        bit           in_column;
        r = '0;
        nwords = live_height() * WORDS_PER_LEVEL;
        rel = int'(y) - int'(base_level_now);
        in_column = (rel >= 0) && (rel < live_height());
        cidx = int'(x) | (int'(z) << 4) | (rel << SLICE_BITS);
        case (req)
            REQ_TEST:
            begin
                if (in_column)
                    r.cell_bit = column_words[cidx >> 6][cidx & 63];
            end
            REQ_SET:
            begin
                if (in_column)
                begin
                    column_words[cidx >> 6][cidx & 63] = 1'b1;
                    r.cell_bit = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                foreach (column_words[i])
                    column_words[i] = '0;
            end
            REQ_COUNT:
            begin
                for (int i = 0; i < nwords; i++)
                begin
                    r.set_count = r.set_count + 18'($countones(column_words[i]));
                    if (column_words[i] != '0)
                        r.used_words = 12'(i + 1);
                end
            end
            REQ_READ:
            begin
                if (int'(widx) < nwords)
                    r.word_value = column_words[widx];
            end
            REQ_LOAD:
            begin
                if (int'(widx) < nwords)
                begin
                    column_words[widx] = wdata;
                    r.word_value = wdata;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic send_req(input logic [2:0] req, input logic [3:0] x,
            input logic signed [15:0] y, input logic [3:0] z, input logic [10:0] widx,
            input logic [63:0] wdata);
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= req;
        cell_x     <= x;
        cell_y     <= y;
        cell_z     <= z;
        word_index <= widx;
        word_data  <= wdata;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        reply_fifo[reply_wr_count % REPLY_DEPTH] = mask_reply_for(req, x, y, z, widx, wdata);
        reply_wr_count++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_BASE_LEVEL)
            base_level_now = data;
        else
            level_count_now = data[9:0];
    endtask

    task automatic wait_replies_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reply_wr_count != reply_rd_count)
            @(posedge clk);
    endtask

    task automatic send_random_req();
        int                 pick;
        int                 height;
        int                 nwords;
        int                 rel;
        logic [2:0]         req;
        logic [3:0]         x;
        logic [3:0]         z;
        logic signed [15:0] y;
        logic [10:0]        widx;
        height = live_height();
        nwords = height * WORDS_PER_LEVEL;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            req = REQ_TEST;
        else if (pick < 62)
            req = REQ_SET;
        else if (pick < 76)
            req = REQ_READ;
        else if (pick < 90)
            req = REQ_LOAD;
        else if (pick < 94)
            req = REQ_COUNT;
        else if (pick < 96)
            req = REQ_CLEAR;
        else if (pick < 98)
            req = REQ_UNKNOWN_LO;
        else
            req = REQ_UNKNOWN_HI;
        x = 4'($urandom);
        z = 4'($urandom);
        pick = $urandom_range(0, 9);
        if (height == 0 || pick == 0)
            y = 16'($urandom);
        else
        begin
            if (pick == 1)
                rel = ($urandom_range(0, 1) != 0) ? -1 : height;
            else if (pick == 2)
                rel = ($urandom_range(0, 1) != 0) ? 0 : height - 1;
            else
                rel = $urandom_range(0, height - 1);
            y = 16'(int'(base_level_now) + rel);
        end
        // revisit the last set cell so tests see ones
        if (req == REQ_TEST && $urandom_range(0, 9) < 4)
        begin
            x = last_x;
            y = last_y;
            z = last_z;
        end
        if (req == REQ_SET)
        begin
            last_x = x;
            last_y = y;
            last_z = z;
        end
        pick = $urandom_range(0, 9);
        if (nwords == 0 || pick == 0)
            widx = 11'($urandom);
        else if (pick == 1)
            widx = 11'(nwords);
        else
            widx = 11'($urandom_range(0, nwords - 1));
        send_req(req, x, y, z, widx, {$urandom, $urandom});
    endtask

    task automatic test_default_config();
        send_req(REQ_TEST, 4'd0, -16'sd64, 4'd0, 11'd0, 64'd0);
        send_req(REQ_SET, 4'd15, 16'sd319, 4'd15, 11'd0, 64'd0);
        send_req(REQ_SET, 4'd0, 16'sd320, 4'd0, 11'd0, 64'd0);
        send_req(REQ_SET, 4'd0, -16'sd65, 4'd0, 11'd0, 64'd0);
        send_req(REQ_TEST, 4'd15, 16'sd319, 4'd15, 11'd0, 64'd0);
        send_req(REQ_READ, 4'd0, 16'sd0, 4'd0, 11'd1535, 64'd0);
        send_req(REQ_LOAD, 4'd0, 16'sd0, 4'd0, 11'd1536, '1);
        send_req(REQ_READ, 4'd0, 16'sd0, 4'd0, 11'd1536, 64'd0);
        send_req(REQ_LOAD, 4'd0, 16'sd0, 4'd0, 11'd0, '1);
        send_req(REQ_COUNT, 4'd0, 16'sd0, 4'd0, 11'd0, 64'd0);
        send_req(REQ_UNKNOWN_LO, 4'd15, -16'sd1, 4'd15, 11'h7FF, '1);
        send_req(REQ_UNKNOWN_HI, 4'd15, 16'sd32767, 4'd15, 11'h7FF, '1);
    endtask

    task automatic test_extreme_config();
        wait_replies_done();
        write_reg(CFG_BASE_LEVEL, 16'h8000);
        write_reg(CFG_LEVEL_COUNT, 16'hFFFF);
        send_req(REQ_LOAD, 4'd0, 16'sd0, 4'd0, 11'd2047, '1);
        send_req(REQ_READ, 4'd0, 16'sd0, 4'd0, 11'd2047, 64'd0);
        send_req(REQ_SET, 4'd0, -16'sd32257, 4'd0, 11'd0, 64'd0);
        send_req(REQ_SET, 4'd0, 16'sd32767, 4'd0, 11'd0, 64'd0);
        send_req(REQ_TEST, 4'd0, 16'sh8000, 4'd0, 11'd0, 64'd0);
        send_req(REQ_COUNT, 4'd0, 16'sd0, 4'd0, 11'd0, 64'd0);
        send_req(REQ_CLEAR, 4'd0, 16'sd0, 4'd0, 11'd0, 64'd0);
        send_req(REQ_COUNT, 4'd0, 16'sd0, 4'd0, 11'd0, 64'd0);
        send_req(REQ_READ, 4'd0, 16'sd0, 4'd0, 11'd2047, 64'd0);
    endtask

    task automatic test_zero_height();
        wait_replies_done();
        write_reg(CFG_LEVEL_COUNT, 16'h0400);
        send_req(REQ_SET, 4'd0, 16'sh8000, 4'd0, 11'd0, 64'd0);
        send_req(REQ_READ, 4'd0, 16'sd0, 4'd0, 11'd0, 64'd0);
        send_req(REQ_LOAD, 4'd0, 16'sd0, 4'd0, 11'd0, '1);
        send_req(REQ_COUNT, 4'd0, 16'sd0, 4'd0, 11'd0, 64'd0);
    endtask

    task automatic test_height_change();
        wait_replies_done();
        write_reg(CFG_BASE_LEVEL, 16'd0);
        write_reg(CFG_LEVEL_COUNT, 16'd4);
        send_req(REQ_LOAD, 4'd0, 16'sd0, 4'd0, 11'd10, 64'hA5A5_0F0F_1234_5678);
        wait_replies_done();
        write_reg(CFG_LEVEL_COUNT, 16'd2);
        send_req(REQ_READ, 4'd0, 16'sd0, 4'd0, 11'd10, 64'd0);
        send_req(REQ_COUNT, 4'd0, 16'sd0, 4'd0, 11'd0, 64'd0);
        wait_replies_done();
        write_reg(CFG_LEVEL_COUNT, 16'd4);
        send_req(REQ_READ, 4'd0, 16'sd0, 4'd0, 11'd10, 64'd0);
    endtask

    task automatic test_backpressure();
        wait_replies_done();
        write_reg(CFG_BASE_LEVEL, 16'($urandom));
        write_reg(CFG_LEVEL_COUNT, 16'd2);
        tx_idle_en = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) send_random_req();
        wait_replies_done();
        tx_idle_en = 1'b1;
        repeat (20) send_random_req();
    endtask

    task automatic test_random_phases();
        logic [15:0] base;
        logic [9:0]  count;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_replies_done();
            case (p)
                1: base = 16'h8000;
                3: base = 16'h7FFF;
                default:
                    base = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 255) - 128);
            endcase
            case (p)
                2: count = 10'd512;
                5: count = 10'd1023;
                8: count = 10'($urandom_range(9, 600));
                default: count = 10'($urandom_range(1, 8));
            endcase
            write_reg(CFG_BASE_LEVEL, base);
            write_reg(CFG_LEVEL_COUNT, {6'($urandom), count});
            if (p == PHASES - 1)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            repeat (PHASE_ITEMS) send_random_req();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
            input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int burst;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 7);
                out_ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (reply_wr_count == reply_rd_count)
            begin
                $display("%0t: result beat with nothing pending, expected none, actual %0h %0h %0h %0h",
                         $time, cell_bit, set_count, used_words, word_value);
                err_count++;
            end
            else
            begin
                reply_front = reply_fifo[reply_rd_count % REPLY_DEPTH];
                reply_rd_count++;
                check_field("cell_bit", 64'(reply_front.cell_bit), 64'(cell_bit));
                check_field("set_count", 64'(reply_front.set_count), 64'(set_count));
                check_field("used_words", 64'(reply_front.used_words), 64'(used_words));
                check_field("word_value", reply_front.word_value, word_value);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = '0;
        cell_x       = '0;
        cell_y       = '0;
        cell_z       = '0;
        word_index   = '0;
        word_data    = '0;
        foreach (column_words[i])
            column_words[i] = '0;
        base_level_now  = BASE_LEVEL_RST;
        level_count_now = LEVEL_COUNT_RST;
        reply_wr_count  = 0;
        reply_rd_count  = 0;
        err_count       = 0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        long_hold_req   = 1'b0;
        last_x          = '0;
        last_y          = '0;
        last_z          = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_extreme_config();
        test_zero_height();
        test_height_change();
        test_backpressure();
        test_random_phases();

        wait_replies_done();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
